/* rtl/stok_pkg.sv */
// Package: scan modes, token kinds, keyword tables and default widths for the tokenizer.
`default_nettype none
package stok_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int LINE_BITS_DEF   = 24;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int COLUMN_BITS     = 16;
  localparam int KIND_BITS       = 5;

  typedef enum logic [9:0] {
    M_IDLE  = 10'b00_0000_0001,
    M_INT   = 10'b00_0000_0010,
    M_DOT   = 10'b00_0000_0100,
    M_FRAC  = 10'b00_0000_1000,
    M_WORD  = 10'b00_0001_0000,
    M_STR   = 10'b00_0010_0000,
    M_OP    = 10'b00_0100_0000,
    M_SLASH = 10'b00_1000_0000,
    M_LCOM  = 10'b01_0000_0000,
    M_BCOM  = 10'b10_0000_0000
  } scan_mode_t;

  localparam logic [4:0] K_EOF     = 5'd0;
  localparam logic [4:0] K_ILLEGAL = 5'd1;
  localparam logic [4:0] K_NUMBER  = 5'd2;
  localparam logic [4:0] K_STRING  = 5'd3;
  localparam logic [4:0] K_KW_BASE = 5'd4;
  localparam logic [4:0] K_ASSIGN  = 5'd8;
  localparam logic [4:0] K_NOT     = 5'd10;
  localparam logic [4:0] K_LT      = 5'd12;
  localparam logic [4:0] K_GT      = 5'd14;
  localparam logic [4:0] K_PLUS    = 5'd16;
  localparam logic [4:0] K_MINUS   = 5'd17;
  localparam logic [4:0] K_STAR    = 5'd18;
  localparam logic [4:0] K_SLASH   = 5'd19;
  localparam logic [4:0] K_SEMI    = 5'd20;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    case (k)
      2'd0: kw_len = 3'd2;
      2'd1: kw_len = 3'd4;
      2'd2: kw_len = 3'd5;
      default: kw_len = 3'd6;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
    logic [47:0] s;
    case (k)
      2'd0: s = {"if", 32'h0};
      2'd1: s = {"else", 16'h0};
      2'd2: s = {"while", 8'h0};
      default: s = "return";
    endcase
    case (idx)
      3'd0: kw_char = s[47:40];
      3'd1: kw_char = s[39:32];
      3'd2: kw_char = s[31:24];
      3'd3: kw_char = s[23:16];
      3'd4: kw_char = s[15:8];
      3'd5: kw_char = s[7:0];
      default: kw_char = CH_NUL;
    endcase
  endfunction

  function automatic logic [4:0] op_kind(input logic [7:0] p);
    case (p)
      "=": op_kind = K_ASSIGN;
      "!": op_kind = K_NOT;
      "<": op_kind = K_LT;
      default: op_kind = K_GT;
    endcase
  endfunction

endpackage
`default_nettype wire

/* rtl/source_tokenizer.sv */
// Top level: streaming tokenizer, one source byte per word in, one token per word out.
//
//  channel | handshake          | payload
//  in      | in_valid/in_ready   | text_byte, end_of_text
//  out     | out_valid/out_ready | token_kind, token_start, token_length,
//          |                     | token_row, token_col, last_of_run
//
// One byte per cycle while in_ready is high: each accepted word is scanned in the cycle it is taken,
// and its 0..3 tokens land in a 4-entry output queue, visible the next cycle.
// in_ready needs room for three tokens after this cycle's pop; with the output
// stalled, in_ready drops once two tokens wait in the queue.
// rst is synchronous and returns scanner state to line 1, column 1, offset 0.
`default_nettype none
module source_tokenizer #(
  parameter int OFFSET_BITS = stok_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = stok_pkg::LINE_BITS_DEF,
  parameter int LENGTH_BITS = stok_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [7:0]                          text_byte,
  input  wire logic                                end_of_text,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [stok_pkg::KIND_BITS-1:0]           token_kind,
  output logic [OFFSET_BITS-1:0]                   token_start,
  output logic [LENGTH_BITS-1:0]                   token_length,
  output logic [LINE_BITS-1:0]                     token_row,
  output logic [stok_pkg::COLUMN_BITS-1:0]         token_col,
  output logic                                     last_of_run
);
  import stok_pkg::*;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic                   last;
  } tok_t;

  localparam logic [LENGTH_BITS-1:0] LEN_TOP  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_TOP = '1;
  localparam logic [COLUMN_BITS-1:0] COL_TOP  = '1;

  scan_mode_t               mode, mode_next;
  logic [OFFSET_BITS-1:0]   byte_position, byte_position_next;
  logic [LINE_BITS-1:0]     current_line, current_line_next;
  logic [COLUMN_BITS-1:0]   current_column, current_column_next;
  logic [OFFSET_BITS-1:0]   start_offset, start_offset_next;
  logic [LINE_BITS-1:0]     start_line, start_line_next;
  logic [COLUMN_BITS-1:0]   start_column, start_column_next;
  logic [LENGTH_BITS-1:0]   run_length, run_length_next;
  logic [3:0]               keyword_hits, keyword_hits_next;
  logic [7:0]               pending_first, pending_first_next;
  logic                     block_star_seen, block_star_seen_next;
  logic [OFFSET_BITS-1:0]   dot_offset, dot_offset_next;
  logic [COLUMN_BITS-1:0]   dot_column, dot_column_next;

  tok_t       fifo [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  tok_t       toks [3];
  logic [1:0] cnt, cnt_fin;
  logic       accept, pop, do_idle, is_end;
  logic [7:0] c;
  logic       c_dig, c_alp, c_word, c_blank;
  logic [3:0] hits_upd, hits0;
  logic [4:0] wkind;
  logic [LENGTH_BITS-1:0] rl_inc, rl_inc2;
  logic [2:0] count_after_pop;

  assign c       = text_byte;
  assign c_dig   = (c >= "0") && (c <= "9");
  assign c_alp   = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  assign c_word  = c_alp || c_dig || (c == CH_UNDER);
  assign c_blank = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  assign is_end  = end_of_text || (c == CH_NUL);

  assign pop             = out_valid && out_ready;
  assign count_after_pop = count - {2'b00, pop};
  assign in_ready        = (count_after_pop <= 3'd1);
  assign accept          = in_valid && in_ready;

  assign rl_inc  = (run_length == LEN_TOP) ? run_length : run_length + 1'b1;
  assign rl_inc2 = (rl_inc == LEN_TOP) ? rl_inc : rl_inc + 1'b1;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hits_upd[k] = keyword_hits[k] && (run_length < LENGTH_BITS'(kw_len(2'(k))))
                    && (kw_char(2'(k), run_length[2:0]) == c);
      hits0[k]    = (kw_char(2'(k), 3'd0) == c);
    end
    wkind = K_ILLEGAL;
    for (int k = 3; k >= 0; k--) begin
      if (keyword_hits[k] && (run_length == LENGTH_BITS'(kw_len(2'(k)))))
        wkind = K_KW_BASE + 5'(k);
    end
  end

  always_comb begin
    mode_next            = mode;
    byte_position_next   = byte_position;
    current_line_next    = current_line;
    current_column_next  = current_column;
    start_offset_next    = start_offset;
    start_line_next      = start_line;
    start_column_next    = start_column;
    run_length_next      = run_length;
    keyword_hits_next    = keyword_hits;
    pending_first_next   = pending_first;
    block_star_seen_next = block_star_seen;
    dot_offset_next      = dot_offset;
    dot_column_next      = dot_column;
    cnt                  = 2'd0;
    do_idle              = 1'b0;
    for (int i = 0; i < 3; i++) toks[i] = '0;

    if (is_end) begin
      case (mode)
        M_INT, M_FRAC: begin
          toks[cnt] = '{K_NUMBER, start_offset, run_length, start_line, start_column, 1'b0};
          cnt = cnt + 2'd1;
        end
        M_DOT: begin
          toks[cnt] = '{K_NUMBER, start_offset, run_length, start_line, start_column, 1'b0};
          cnt = cnt + 2'd1;
          toks[cnt] = '{K_ILLEGAL, dot_offset, LENGTH_BITS'(1), current_line, dot_column, 1'b0};
          cnt = cnt + 2'd1;
        end
        M_WORD: begin
          toks[cnt] = '{wkind, start_offset, run_length, start_line, start_column, 1'b0};
          cnt = cnt + 2'd1;
        end
        M_STR: begin
          toks[cnt] = '{K_ILLEGAL, start_offset, run_length, start_line, start_column, 1'b0};
          cnt = cnt + 2'd1;
        end
        M_OP: begin
          toks[cnt] = '{op_kind(pending_first), start_offset, run_length, start_line,
                        start_column, 1'b0};
          cnt = cnt + 2'd1;
        end
        M_SLASH: begin
          toks[cnt] = '{K_SLASH, start_offset, run_length, start_line, start_column, 1'b0};
          cnt = cnt + 2'd1;
        end
        default: ;
      endcase
      toks[cnt] = '{K_EOF, byte_position, '0, current_line, current_column, 1'b0};
      cnt = cnt + 2'd1;
      mode_next            = M_IDLE;
      byte_position_next   = '0;
      current_line_next    = LINE_BITS'(1);
      current_column_next  = COLUMN_BITS'(1);
      start_offset_next    = '0;
      start_line_next      = LINE_BITS'(1);
      start_column_next    = COLUMN_BITS'(1);
      run_length_next      = '0;
      keyword_hits_next    = 4'hF;
      pending_first_next   = CH_NUL;
      block_star_seen_next = 1'b0;
      dot_offset_next      = '0;
      dot_column_next      = COLUMN_BITS'(1);
    end else begin
      case (mode)
        M_IDLE: do_idle = 1'b1;
        M_INT: begin
          if (c_dig) run_length_next = rl_inc;
          else if (c == ".") begin
            dot_offset_next = byte_position;
            dot_column_next = current_column;
            mode_next       = M_DOT;
          end else begin
            toks[cnt] = '{K_NUMBER, start_offset, run_length, start_line, start_column, 1'b0};
            cnt = cnt + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_DOT: begin
          if (c_dig) begin
            run_length_next = rl_inc2;
            mode_next       = M_FRAC;
          end else begin
            toks[cnt] = '{K_NUMBER, start_offset, run_length, start_line, start_column, 1'b0};
            cnt = cnt + 2'd1;
            toks[cnt] = '{K_ILLEGAL, dot_offset, LENGTH_BITS'(1), current_line, dot_column,
                          1'b0};
            cnt = cnt + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_FRAC: begin
          if (c_dig) run_length_next = rl_inc;
          else begin
            toks[cnt] = '{K_NUMBER, start_offset, run_length, start_line, start_column, 1'b0};
            cnt = cnt + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_WORD: begin
          if (c_word) begin
            keyword_hits_next = hits_upd;
            run_length_next   = rl_inc;
          end else begin
            toks[cnt] = '{wkind, start_offset, run_length, start_line, start_column, 1'b0};
            cnt = cnt + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_STR: begin
          run_length_next = rl_inc;
          if (c == "\"") begin
            toks[cnt] = '{K_STRING, start_offset, rl_inc, start_line, start_column, 1'b0};
            cnt = cnt + 2'd1;
            mode_next = M_IDLE;
          end
        end
        M_OP: begin
          if (c == "=") begin
            run_length_next = rl_inc;
            toks[cnt] = '{op_kind(pending_first) + 5'd1, start_offset, rl_inc, start_line,
                          start_column, 1'b0};
            cnt = cnt + 2'd1;
            mode_next = M_IDLE;
          end else begin
            toks[cnt] = '{op_kind(pending_first), start_offset, run_length, start_line,
                          start_column, 1'b0};
            cnt = cnt + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == "/") mode_next = M_LCOM;
          else if (c == "*") begin
            block_star_seen_next = 1'b0;
            mode_next            = M_BCOM;
          end else begin
            toks[cnt] = '{K_SLASH, start_offset, run_length, start_line, start_column, 1'b0};
            cnt = cnt + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_LCOM: begin
          if (c == "\n") do_idle = 1'b1;
        end
        M_BCOM: begin
          if (block_star_seen && (c == "/")) begin
            block_star_seen_next = 1'b0;
            mode_next            = M_IDLE;
          end else begin
            block_star_seen_next = (c == "*");
          end
        end
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        mode_next = M_IDLE;
        if (!c_blank) begin
          start_offset_next = byte_position;
          start_line_next   = current_line;
          start_column_next = current_column;
          run_length_next   = LENGTH_BITS'(1);
          if (c_dig) mode_next = M_INT;
          else if (c_alp || (c == CH_UNDER)) begin
            keyword_hits_next = hits0;
            mode_next         = M_WORD;
          end else if (c == "\"") mode_next = M_STR;
          else if ((c == "=") || (c == "!") || (c == "<") || (c == ">")) begin
            pending_first_next = c;
            mode_next          = M_OP;
          end else if (c == "/") mode_next = M_SLASH;
          else begin
            toks[cnt].start = byte_position;
            toks[cnt].len   = LENGTH_BITS'(1);
            toks[cnt].line  = current_line;
            toks[cnt].col   = current_column;
            case (c)
              "+": toks[cnt].kind = K_PLUS;
              "-": toks[cnt].kind = K_MINUS;
              "*": toks[cnt].kind = K_STAR;
              ";": toks[cnt].kind = K_SEMI;
              default: toks[cnt].kind = K_ILLEGAL;
            endcase
            cnt = cnt + 2'd1;
          end
        end
      end

      byte_position_next = byte_position + 1'b1;
      if (c == "\n") begin
        if (current_line != LINE_TOP) current_line_next = current_line + 1'b1;
        current_column_next = COLUMN_BITS'(1);
      end else if (current_column != COL_TOP) begin
        current_column_next = current_column + 1'b1;
      end
    end

    cnt_fin = cnt;
    for (int i = 0; i < 3; i++) toks[i].last = (2'(i + 1) == cnt_fin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= M_IDLE;
      byte_position   <= '0;
      current_line    <= LINE_BITS'(1);
      current_column  <= COLUMN_BITS'(1);
      start_offset    <= '0;
      start_line      <= LINE_BITS'(1);
      start_column    <= COLUMN_BITS'(1);
      run_length      <= '0;
      keyword_hits    <= 4'hF;
      pending_first   <= CH_NUL;
      block_star_seen <= 1'b0;
      dot_offset      <= '0;
      dot_column      <= COLUMN_BITS'(1);
      wr_ptr          <= '0;
      rd_ptr          <= '0;
      count           <= '0;
    end else begin
      if (accept) begin
        mode            <= mode_next;
        byte_position   <= byte_position_next;
        current_line    <= current_line_next;
        current_column  <= current_column_next;
        start_offset    <= start_offset_next;
        start_line      <= start_line_next;
        start_column    <= start_column_next;
        run_length      <= run_length_next;
        keyword_hits    <= keyword_hits_next;
        pending_first   <= pending_first_next;
        block_star_seen <= block_star_seen_next;
        dot_offset      <= dot_offset_next;
        dot_column      <= dot_column_next;
        wr_ptr          <= wr_ptr + cnt_fin;
      end
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count_after_pop + (accept ? {1'b0, cnt_fin} : 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < cnt_fin) fifo[wr_ptr + 2'(i)] <= toks[i];
      end
    end
  end

  assign out_valid    = (count != 3'd0);
  assign token_kind   = fifo[rd_ptr].kind;
  assign token_start  = fifo[rd_ptr].start;
  assign token_length = fifo[rd_ptr].len;
  assign token_row    = fifo[rd_ptr].line;
  assign token_col    = fifo[rd_ptr].col;
  assign last_of_run  = fifo[rd_ptr].last;

  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("token queue overfilled");
  a_eof_resets: assert property (@(posedge clk) disable iff (rst)
      (accept && is_end) |=> (mode == M_IDLE && byte_position == '0))
    else $error("end of text did not reset scanner");
  a_eof_emits: assert property (@(posedge clk) disable iff (rst)
      (accept && is_end) |-> (cnt_fin != 2'd0))
    else $error("end of text produced no token");
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
      in_ready |-> (count_after_pop <= 3'd1))
    else $error("input taken without queue room");

endmodule
`default_nettype wire

/* bench/tb_source_tokenizer.sv */
// Testbench for source_tokenizer: directed and random byte streams checked against a built-in scanner model.
`timescale 1ns / 1ps
module tb_source_tokenizer;
  import stok_pkg::*;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] start;
    logic [15:0] length;
    logic [23:0] line;
    logic [15:0] column;
    logic        last;
  } token_t;

  class token_board;
    scan_mode_t  mode;
    logic [31:0] pos, st_off, dot_off;
    logic [23:0] cur_line, st_line;
    logic [15:0] cur_col, st_col, dot_col, run_len;
    logic [3:0]  hits;
    logic [7:0]  first;
    bit          star;
    token_t      pending_tokens[$];
    int          n_err;
    token_t      batch[$];

    function new();
      n_err = 0;
      clear();
    endfunction

    function void clear();
      mode = M_IDLE; pos = 0; cur_line = 1; cur_col = 1;
      st_off = 0; st_line = 1; st_col = 1; run_len = 0;
      hits = 4'hF; first = 0; star = 0; dot_off = 0; dot_col = 1;
    endfunction

    function void emit(logic [4:0] k, logic [31:0] s, logic [15:0] l,
                       logic [23:0] ln, logic [15:0] c);
      token_t t;
      t.kind = k; t.start = s; t.length = l; t.line = ln; t.column = c; t.last = 0;
      batch.push_back(t);
    endfunction

    function void emit_cur(logic [4:0] k);
      emit(k, st_off, run_len, st_line, st_col);
    endfunction

    function void grow();
      if (run_len != 16'hFFFF) run_len++;
    endfunction

    function void match_kw(logic [7:0] c);
      logic [47:0] w;
      int kl;
      for (int k = 0; k < 4; k++) begin
        case (k)
          0: begin w = {"if", 32'h0}; kl = 2; end
          1: begin w = {"else", 16'h0}; kl = 4; end
          2: begin w = {"while", 8'h0}; kl = 5; end
          default: begin w = "return"; kl = 6; end
        endcase
        if (run_len >= kl || w[47 - 8 * run_len -: 8] != c) hits[k] = 0;
      end
    endfunction

    function logic [4:0] word_kind();
      int lens[4] = '{2, 4, 5, 6};
      for (int k = 0; k < 4; k++)
        if (hits[k] && run_len == lens[k]) return K_KW_BASE + 5'(k);
      return K_ILLEGAL;
    endfunction

    function logic [4:0] cmp_kind();
      case (first)
        "=": return K_ASSIGN;
        "!": return K_NOT;
        "<": return K_LT;
        default: return K_GT;
      endcase
    endfunction

    function bit is_dig(logic [7:0] c); return c >= "0" && c <= "9"; endfunction
    function bit is_alp(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit scan(logic [7:0] c);
      case (mode)
        M_IDLE: begin
          if (c == " " || (c >= 9 && c <= 13)) return 1;
          st_off = pos; st_line = cur_line; st_col = cur_col; run_len = 1;
          if (is_dig(c)) mode = M_INT;
          else if (is_alp(c) || c == CH_UNDER) begin
            hits = 4'hF; run_len = 0; match_kw(c); run_len = 1; mode = M_WORD;
          end else if (c == "\"") mode = M_STR;
          else if (c == "=" || c == "!" || c == "<" || c == ">") begin
            first = c; mode = M_OP;
          end else if (c == "/") mode = M_SLASH;
          else if (c == "+") emit_cur(K_PLUS);
          else if (c == "-") emit_cur(K_MINUS);
          else if (c == "*") emit_cur(K_STAR);
          else if (c == ";") emit_cur(K_SEMI);
          else emit_cur(K_ILLEGAL);
          return 1;
        end
        M_INT: begin
          if (is_dig(c)) begin grow(); return 1; end
          if (c == ".") begin dot_off = pos; dot_col = cur_col; mode = M_DOT; return 1; end
          emit_cur(K_NUMBER);
        end
        M_DOT: begin
          if (is_dig(c)) begin grow(); grow(); mode = M_FRAC; return 1; end
          emit_cur(K_NUMBER);
          emit(K_ILLEGAL, dot_off, 1, cur_line, dot_col);
        end
        M_FRAC: begin
          if (is_dig(c)) begin grow(); return 1; end
          emit_cur(K_NUMBER);
        end
        M_WORD: begin
          if (is_alp(c) || is_dig(c) || c == CH_UNDER) begin match_kw(c); grow(); return 1; end
          emit_cur(word_kind());
        end
        M_STR: begin
          grow();
          if (c == "\"") begin emit_cur(K_STRING); mode = M_IDLE; end
          return 1;
        end
        M_OP: begin
          if (c == "=") begin
            grow(); emit_cur(cmp_kind() + 5'd1); mode = M_IDLE; return 1;
          end
          emit_cur(cmp_kind());
        end
        M_SLASH: begin
          if (c == "/") begin mode = M_LCOM; return 1; end
          if (c == "*") begin star = 0; mode = M_BCOM; return 1; end
          emit_cur(K_SLASH);
        end
        M_LCOM: if (c != "\n") return 1;
        M_BCOM: begin
          if (star && c == "/") begin star = 0; mode = M_IDLE; end
          else star = (c == "*");
          return 1;
        end
        default: ;
      endcase
      mode = M_IDLE;
      return 0;
    endfunction

    function void note_word(logic [7:0] c, logic eot);
      batch.delete();
      if (eot || c == CH_NUL) begin
        case (mode)
          M_INT, M_FRAC: emit_cur(K_NUMBER);
          M_DOT: begin
            emit_cur(K_NUMBER);
            emit(K_ILLEGAL, dot_off, 1, cur_line, dot_col);
          end
          M_WORD: emit_cur(word_kind());
          M_STR: emit_cur(K_ILLEGAL);
          M_OP: emit_cur(cmp_kind());
          M_SLASH: emit_cur(K_SLASH);
          default: ;
        endcase
        emit(K_EOF, pos, 0, cur_line, cur_col);
        clear();
      end else begin
        if (!scan(c)) void'(scan(c));
        pos++;
        if (c == "\n") begin
          if (cur_line != 24'hFFFFFF) cur_line++;
          cur_col = 1;
        end else if (cur_col != 16'hFFFF) cur_col++;
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1;
      foreach (batch[i]) pending_tokens.push_back(batch[i]);
    endfunction

    function void check_token(token_t got);
      token_t e;
      if (pending_tokens.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("ERROR: unexpected token kind=%0d", got.kind);
        return;
      end
      e = pending_tokens.pop_front();
      if (got != e) begin
        n_err++;
        if (n_err <= 10)
          $display("ERROR: exp k%0d s%0d n%0d l%0d c%0d z%0d, got k%0d s%0d n%0d l%0d c%0d z%0d",
                   e.kind, e.start, e.length, e.line, e.column, e.last,
                   got.kind, got.start, got.length, got.line, got.column, got.last);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, end_of_text = 0, out_valid, out_ready = 0, last_of_run;
  logic [7:0] text_byte = 0;
  logic [4:0] token_kind;
  logic [31:0] token_start;
  logic [15:0] token_length, token_col;
  logic [23:0] token_row;
  token_board board = new();
  int cycles = 0;
  int burst_left = 0;

  always begin #5 clk = 1; #5 clk = 0; end

  source_tokenizer i_dut (
    .clk, .rst, .in_valid, .in_ready, .text_byte, .end_of_text,
    .out_valid, .out_ready, .token_kind, .token_start, .token_length,
    .token_row, .token_col, .last_of_run
  );

  always @(posedge clk) begin
    token_t t;
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("source_tokenizer test failed");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      t.kind = token_kind; t.start = token_start; t.length = token_length;
      t.line = token_row; t.column = token_col; t.last = last_of_run;
      board.check_token(t);
    end
    if (rst) out_ready <= 0;
    else if ((cycles / 64) % 3 == 0) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1; text_byte <= b; end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    board.note_word(b, eot);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending_tokens.size() != 0) @(posedge clk);
  endtask

  string frags[] = '{"if ", "else", "while(", "return;", "iff ", "x_1 ", "12.5 ", "7.a",
                     "3. ", "\"ab c\"", "== ", "!=", "<=", ">= ", "= ", "!x", "<", ">",
                     "+-*/", "// c\n", "/* a*\n* */", "/ ", "\n\t", ". ", "42", "_w "};

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    send_text("if else while return x\n");
    send_text("12 3.75 9. 5.x . \"s\n\" = == ! != < <= > >= + - * / ; ");
    send_text("// note\n/* a\n** b */ @");
    send_byte(8'hFF, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h7F, 1'b0);
    send_text("\"open");
    send_byte(8'h00, 1'b0);
    send_text("1.");
    send_byte(8'h55, 1'b1);
    send_text("/* open");
    send_byte(8'h00, 1'b1);
    send_text("<");
    send_byte(8'h00, 1'b0);
    drain();
    repeat (5) @(posedge clk);
    for (int n = 0; n < 20; n++) begin
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) send_text(frags[$urandom_range(0, frags.size() - 1)]);
      else if (r < 9) send_byte(8'($urandom_range(1, 255)), 1'b0);
      else send_byte(8'($urandom_range(0, 255)) & {8{$urandom_range(0, 1) == 1}},
                     1'($urandom_range(0, 1)));
      if (n == 10) begin drain(); repeat (3) @(posedge clk); end
    end
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    drain();
    repeat (20) @(posedge clk);
    if (board.n_err == 0 && board.pending_tokens.size() == 0)
      $display("source_tokenizer test passed");
    else
      $display("source_tokenizer test failed");
    $finish;
  end
endmodule
